/* sv/modular_inverse_unit_core_macros.svh */
// Assertion helpers for the modular inverse core.
`ifndef MODULAR_INVERSE_UNIT_CORE_MACROS_SVH
`define MODULAR_INVERSE_UNIT_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define MIU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("modular inverse core: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MIU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("modular inverse core: assertion failed");

`else

`define MIU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MIU_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* sv/miu_pkg.sv */
package miu_pkg;

	localparam int MIU_OPERAND_BITS = 31;
	// Trial subtractions per quotient before falling back to long division
	localparam int MIU_TRIAL_MAX = 8;

	typedef enum logic [1:0] {
		QS_IDLE,
		QS_TRIAL,
		QS_DIV,
		QS_FIN
	} qstep_state_t;

	typedef enum logic [2:0] {
		TS_IDLE,
		TS_REDUCE,
		TS_CHECK,
		TS_STEP,
		TS_OUT
	} top_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} qs_stat_t;

endpackage

/* sv/modular_inverse_unit_core.sv */
// Channel | Dir | Signals                      | Word
// s       | in  | s_tvalid s_tready s_tdata    | value, modulus
// m       | out | m_tvalid m_tready m_tdata    | inverse
//
// One word in flight; s_tready is high only while the sequencer is idle.
// Each word takes one reduction quotient step in miu_qstep, then one quotient step per
// Euclid step. A quotient step finds a quotient k below 8 by trial subtraction, else it
// runs 8 trial subtractions, then long division.
// A zero modulus skips the sequencer. A stalled output holds the sequencer.
// The shared subtract/compare unit in miu_qstep serves every quotient step.
// Reset clears all control state; a finished word waits in the output register.
`include "modular_inverse_unit_core_macros.svh"

module modular_inverse_unit_core
	import miu_pkg::*;
#(
	parameter int OPERAND_BITS = MIU_OPERAND_BITS,
	localparam int S_W = ((2 * OPERAND_BITS + 7) / 8) * 8,
	localparam int M_W = ((OPERAND_BITS + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [S_W-1:0] s_tdata,   // value, modulus, zero pad
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [M_W-1:0] m_tdata    // inverse, zero pad
);

	localparam int N = OPERAND_BITS;

	top_state_t   state_q, state_d;
	logic         m_valid_q;

	logic [N-1:0] mod_q, num_q, den_q, cur_q, prev_q, res_q, out_q;
	logic         odd_q;

	logic [N-1:0] in_value, in_mod;
	logic         accept;
	logic         den_gt1;
	logic         out_load;

	logic         qs_start;
	logic [N-1:0] qs_dividend, qs_divisor, qs_cur, qs_prev, qs_rem, qs_nxt;
	qs_stat_t     qs_stat;

	assign in_value = s_tdata[N-1:0];
	assign in_mod   = s_tdata[2*N-1:N];
	assign s_tready = (state_q == TS_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign den_gt1  = (den_q[N-1:1] != '0);
	assign out_load = (state_q == TS_OUT) && (!m_valid_q || m_tready);

	always_comb begin
		qs_start = (accept && (in_mod != '0)) || ((state_q == TS_CHECK) && den_gt1);
		if (state_q == TS_IDLE) begin
			qs_dividend = in_value;
			qs_divisor  = in_mod;
			qs_cur      = '0;
			qs_prev     = '0;
		end else begin
			qs_dividend = num_q;
			qs_divisor  = den_q;
			qs_cur      = cur_q;
			qs_prev     = prev_q;
		end
	end

	miu_qstep #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_qstep (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (qs_start),
		.dividend(qs_dividend),
		.divisor (qs_divisor),
		.cur     (qs_cur),
		.prev    (qs_prev),
		.stat    (qs_stat),
		.rem     (qs_rem),
		.nxt     (qs_nxt)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			TS_IDLE: begin
				if (accept)
					state_d = (in_mod == '0) ? TS_OUT : TS_REDUCE;
			end
			TS_REDUCE: begin
				if (qs_stat.done)
					state_d = TS_CHECK;
			end
			TS_CHECK: begin
				state_d = den_gt1 ? TS_STEP : TS_OUT;
			end
			TS_STEP: begin
				if (qs_stat.done)
					state_d = TS_CHECK;
			end
			TS_OUT: begin
				if (out_load)
					state_d = TS_IDLE;
			end
			default: begin
				state_d = TS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= TS_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			TS_IDLE: begin
				if (accept) begin
					mod_q <= in_mod;
					res_q <= N'(1);
				end
			end
			TS_REDUCE: begin
				if (qs_stat.done) begin
					num_q  <= mod_q;
					den_q  <= qs_rem;
					cur_q  <= N'(1);
					prev_q <= '0;
					odd_q  <= 1'b0;
				end
			end
			TS_CHECK: begin
				// chain done: fold the sign back in
				if (!den_gt1)
					res_q <= odd_q ? (mod_q - cur_q) : cur_q;
			end
			TS_STEP: begin
				if (qs_stat.done) begin
					prev_q <= cur_q;
					cur_q  <= qs_nxt;
					odd_q  <= ~odd_q;
					num_q  <= den_q;
					den_q  <= qs_rem;
				end
			end
			TS_OUT: begin
				if (out_load)
					out_q <= res_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_W'(out_q);

	`MIU_ASSERT_IMP(a_ready_unit_idle, clk, arst_n, s_tready, !qs_stat.busy)
	`MIU_ASSERT_IMP(a_done_in_wait, clk, arst_n, qs_stat.done, (state_q == TS_REDUCE) || (state_q == TS_STEP))
	`MIU_ASSERT_NXT(a_parity_hold, clk, arst_n, (state_q == TS_STEP) && !qs_stat.done, $stable(odd_q))
	`MIU_ASSERT_NXT(a_busy_after_accept, clk, arst_n, accept, !s_tready)

endmodule

/* sv/miu_qstep.sv */
// One quotient step: rem = dividend mod divisor, nxt = (dividend / divisor) * cur + prev,
// both taken modulo 2^OPERAND_BITS. A single subtract/compare unit and a single adder
// serve the trial-subtraction phase and the long-division phase.
module miu_qstep
	import miu_pkg::*;
#(
	parameter int OPERAND_BITS = MIU_OPERAND_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OPERAND_BITS-1:0] dividend,
	input  logic [OPERAND_BITS-1:0] divisor,
	input  logic [OPERAND_BITS-1:0] cur,
	input  logic [OPERAND_BITS-1:0] prev,
	output qs_stat_t                stat,
	output logic [OPERAND_BITS-1:0] rem,
	output logic [OPERAND_BITS-1:0] nxt
);

	localparam int N  = OPERAND_BITS;
	localparam int CW = $clog2(N);

	qstep_state_t  state_q, state_d;
	logic          done_q;
	logic [CW-1:0] cnt_q;

	logic [N-1:0]  rem_q, div_q, cur_q, acc_q, m_q, p_q, x_q;

	logic [N:0]    t_div;
	logic [N:0]    sub_a;
	logic [N+1:0]  diff;
	logic          ge;
	logic          trial_last;
	logic [N-1:0]  add_a, add_b, sum;

	// Shared compare/subtract
	always_comb begin
		t_div = {p_q, x_q[N-1]};
		sub_a = (state_q == QS_DIV) ? t_div : {1'b0, rem_q};
		diff  = {1'b0, sub_a} - {2'b00, div_q};
		ge    = ~diff[N+1];
		trial_last = (cnt_q == CW'(MIU_TRIAL_MAX - 1));
	end

	// Shared adder for the cofactor
	always_comb begin
		case (state_q)
			QS_TRIAL: begin
				add_a = acc_q;
				add_b = cur_q;
			end
			QS_DIV: begin
				add_a = {m_q[N-2:0], 1'b0};
				add_b = ge ? cur_q : '0;
			end
			default: begin
				add_a = acc_q;
				add_b = m_q;
			end
		endcase
		sum = add_a + add_b;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			QS_IDLE: begin
				if (start)
					state_d = QS_TRIAL;
			end
			QS_TRIAL: begin
				if (!ge)
					state_d = QS_FIN;
				else if (trial_last)
					state_d = QS_DIV;
			end
			QS_DIV: begin
				if (cnt_q == '0)
					state_d = QS_FIN;
			end
			QS_FIN: begin
				state_d = QS_IDLE;
			end
			default: begin
				state_d = QS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= QS_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == QS_FIN);
			case (state_q)
				QS_IDLE: begin
					if (start)
						cnt_q <= '0;
				end
				QS_TRIAL: begin
					if (ge)
						cnt_q <= trial_last ? CW'(N - 1) : cnt_q + 1'b1;
				end
				QS_DIV: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			QS_IDLE: begin
				if (start) begin
					rem_q <= dividend;
					div_q <= divisor;
					cur_q <= cur;
					acc_q <= prev;
					m_q   <= '0;
				end
			end
			QS_TRIAL: begin
				if (ge) begin
					rem_q <= diff[N-1:0];
					acc_q <= sum;
					if (trial_last) begin
						// hand the leftover to long division
						x_q <= diff[N-1:0];
						p_q <= '0;
					end
				end else begin
					p_q <= rem_q;
				end
			end
			QS_DIV: begin
				p_q <= ge ? diff[N-1:0] : t_div[N-1:0];
				x_q <= {x_q[N-2:0], 1'b0};
				m_q <= sum;
			end
			QS_FIN: begin
				rem_q <= p_q;
				acc_q <= sum;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign stat.busy = (state_q != QS_IDLE);
	assign stat.done = done_q;
	assign rem       = rem_q;
	assign nxt       = acc_q;

endmodule
